### src/tfd_pkg.sv
// Shared types and constants of the texture fragment depth unit.
// Used by the front, divider, back and top level modules.
package tfd_pkg;

  localparam int TEX_ADDR_BITS_DEF = 16;
  localparam int FIFO_DEPTH        = 4;
  localparam int DIV_W             = 36;        // dividend width: interpolant plus 4 fraction bits
  localparam int DIV_STAGES        = DIV_W;     // one quotient bit per stage
  localparam int QUO_KEEP          = 12;        // 8 integer bits survive the masks, 4 fraction bits
  localparam int ADDR_WIDE         = 23;        // 8-bit row index shifted by up to 15
  localparam int IN_DATA_W         = 184;
  localparam int OUT_DATA_W        = 56;

  localparam logic [31:0] ALPHA_MASK = 32'hff000000;
  localparam logic [4:0]  WEIGHT_ONE = 5'd16;

  localparam logic [1:0] REG_S_MASK      = 2'd0;
  localparam logic [1:0] REG_T_MASK      = 2'd1;
  localparam logic [1:0] REG_ROW_SHIFT   = 2'd2;
  localparam logic [1:0] REG_FILTER_MODE = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic FILTER_NEAREST = 1'b0;

  typedef struct packed {
    logic        is_frag;
    logic        live;        // fragment passed depth test and has a usable reciprocal
    logic [15:0] texel_addr;
    logic [31:0] texel_value;
    logic [15:0] frag_depth;
    logic [31:0] s_over_w;
    logic [31:0] t_over_w;
    logic [31:0] one_over_w;
  } item_t;

  typedef struct packed {
    logic        is_frag;
    logic        live;
    logic [15:0] texel_addr;
    logic [31:0] texel_value;
    logic [15:0] frag_depth;
  } side_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } head_t;

endpackage

### src/tfd_front.sv
// Front of the texture fragment depth unit: accepts requests, classifies them
// and queues them for the back. Depends on tfd_pkg.
module tfd_front import tfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 pop,
  output head_t                head
);

  localparam int PW = $clog2(FIFO_DEPTH);

  item_t         q_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  item_t         cls;
  logic          push;

  always_comb begin
    cls.is_frag     = in_tdata[0] != MODE_LOAD;
    cls.texel_addr  = in_tdata[16:1];
    cls.texel_value = in_tdata[48:17];
    cls.frag_depth  = in_tdata[64:49];
    cls.s_over_w    = in_tdata[112:81];
    cls.t_over_w    = in_tdata[144:113];
    cls.one_over_w  = in_tdata[176:145];
    // not live on zero reciprocal or failed depth test
    cls.live        = (in_tdata[176:145] != 32'd0) && (in_tdata[64:49] >= in_tdata[80:65]);
  end

  assign in_tready = count_r != (PW+1)'(FIFO_DEPTH);
  assign push      = in_tvalid && in_tready;

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  assign head.vld  = count_r != '0;
  assign head.item = q_r[rd_ptr_r];

endmodule

### src/tfd_div.sv
// Pipelined restoring divider, one quotient bit per stage; keeps the low
// quotient bits only. Depends on tfd_pkg.
module tfd_div import tfd_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         dvd_i,
  input  logic [31:0]         dsr_i,
  output logic [QUO_KEEP-1:0] quo_o
);

  logic [DIV_W-1:0]    dvd_r [DIV_STAGES];
  logic [31:0]         rem_r [DIV_STAGES];
  logic [31:0]         dsr_r [DIV_STAGES];
  logic [QUO_KEEP-1:0] quo_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DIV_W-1:0]    dvd_in;
    logic [31:0]         rem_in;
    logic [31:0]         dsr_in;
    logic [QUO_KEEP-1:0] quo_in;
    logic [32:0]         trial;
    logic                ge;

    if (g == 0) begin : g_first
      assign dvd_in = {dvd_i, 4'b0000};
      assign rem_in = '0;
      assign dsr_in = dsr_i;
      assign quo_in = '0;
    end else begin : g_next
      assign dvd_in = dvd_r[g-1];
      assign rem_in = rem_r[g-1];
      assign dsr_in = dsr_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    assign trial = {rem_in, dvd_in[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? 32'(trial - {1'b0, dsr_in}) : trial[31:0];
        dvd_r[g] <= {dvd_in[DIV_W-2:0], 1'b0};
        dsr_r[g] <= dsr_in;
        quo_r[g] <= {quo_in[QUO_KEEP-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

### src/tfd_back.sv
// Back of the texture fragment depth unit: coordinate division, replicated
// texture store, depth-gated bilinear or nearest blend and result register.
// Depends on tfd_pkg and tfd_div.
module tfd_back import tfd_pkg::*; #(
  parameter int TEX_ADDR_BITS = TEX_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  head_t                 head,
  output logic                  pop,
  input  logic [7:0]            s_mask,
  input  logic [7:0]            t_mask,
  input  logic [3:0]            row_shift,
  input  logic                  filter_mode,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW    = TEX_ADDR_BITS;
  localparam int WORDS = 1 << AW;

  logic en;

  // divider section
  logic [QUO_KEEP-1:0] qs, qt;
  side_t d_side_r [DIV_STAGES];
  logic  d_vld_r  [DIV_STAGES];
  side_t head_side;

  // fetch stage
  logic           m_vld_r;
  side_t          m_side_r;
  logic [3:0]     m_a_r, m_c_r;
  logic [31:0]    tex [4];
  logic [AW-1:0]  rd_addr [4];
  logic [7:0]     s_int, t_int;
  side_t          e_side;
  logic           e_vld;
  logic           do_load;

  // blend stages
  logic           b_vld_r;
  side_t          b_side_r;
  logic           b_write_r, b_near_r;
  logic [31:0]    b_t0_r;
  logic [3:0]     b_c_r;
  logic [12:0]    b_top_r [3];
  logic [12:0]    b_bot_r [3];
  logic           m_write;
  logic [4:0]     wb, wd;
  logic [7:0]     blend_ch [3];

  logic           out_vld_r;
  logic           wr_px_r;
  logic [31:0]    color_r;
  logic [15:0]    depth_r;
  logic [31:0]    color_nxt;

  assign en  = !out_vld_r || out_tready;
  assign pop = en && head.vld;

  assign head_side.is_frag     = head.item.is_frag;
  assign head_side.live        = head.item.live;
  assign head_side.texel_addr  = head.item.texel_addr;
  assign head_side.texel_value = head.item.texel_value;
  assign head_side.frag_depth  = head.item.frag_depth;

  tfd_div u_div_s (
    .clk   (clk),
    .en    (en),
    .dvd_i (head.item.s_over_w),
    .dsr_i (head.item.one_over_w),
    .quo_o (qs)
  );

  tfd_div u_div_t (
    .clk   (clk),
    .en    (en),
    .dvd_i (head.item.t_over_w),
    .dsr_i (head.item.one_over_w),
    .quo_o (qt)
  );

  // sideband travels alongside the divider stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[g] <= 1'b0;
      end else if (en) begin
        d_vld_r[g] <= (g == 0) ? head.vld : d_vld_r[(g == 0) ? 0 : g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_side_r[g] <= (g == 0) ? head_side : d_side_r[(g == 0) ? 0 : g-1];
      end
    end
  end

  assign e_side  = d_side_r[DIV_STAGES-1];
  assign e_vld   = d_vld_r[DIV_STAGES-1];
  assign s_int   = qs[11:4];
  assign t_int   = qt[11:4];
  assign do_load = en && e_vld && !e_side.is_frag;

  // one store copy per neighbour, all written by every load
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [31:0]          mem [WORDS];
    logic [7:0]           sk, tk;
    logic [ADDR_WIDE-1:0] wide;

    assign sk   = (s_int + 8'(k % 2)) & s_mask;
    assign tk   = (t_int + 8'(k / 2)) & t_mask;
    assign wide = ({15'd0, tk} << row_shift) | {15'd0, sk};
    assign rd_addr[k] = wide[AW-1:0];

    always_ff @(posedge clk) begin
      if (do_load) begin
        mem[AW'(e_side.texel_addr)] <= e_side.texel_value;
      end
      if (en) begin
        tex[k] <= mem[rd_addr[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r <= e_side;
      m_a_r    <= qs[3:0];
      m_c_r    <= qt[3:0];
    end
  end

  // bilinear needs every neighbour opaque; nearest only texel0
  always_comb begin
    m_write = m_side_r.live && ((tex[0] & ALPHA_MASK) != '0);
    if (filter_mode != FILTER_NEAREST) begin
      m_write = m_write && ((tex[1] & ALPHA_MASK) != '0) &&
                ((tex[2] & ALPHA_MASK) != '0) && ((tex[3] & ALPHA_MASK) != '0);
    end
  end

  assign wb = WEIGHT_ONE - {1'b0, m_a_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r  <= m_side_r;
      b_write_r <= m_write;
      b_near_r  <= filter_mode == FILTER_NEAREST;
      b_t0_r    <= tex[0];
      b_c_r     <= m_c_r;
      for (int ch = 0; ch < 3; ch++) begin
        b_top_r[ch] <= 13'(wb * tex[0][8*ch +: 8]) + 13'({1'b0, m_a_r} * tex[1][8*ch +: 8]);
        b_bot_r[ch] <= 13'(wb * tex[2][8*ch +: 8]) + 13'({1'b0, m_a_r} * tex[3][8*ch +: 8]);
      end
    end
  end

  assign wd = WEIGHT_ONE - {1'b0, b_c_r};

  always_comb begin
    logic [17:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 18'(wd * b_top_r[ch]) + 18'({1'b0, b_c_r} * b_bot_r[ch]);
      blend_ch[ch] = acc[15:8];
    end
  end

  always_comb begin
    if (!b_write_r) begin
      color_nxt = '0;
    end else if (b_near_r) begin
      color_nxt = b_t0_r;
    end else begin
      color_nxt = {b_t0_r[31:24], blend_ch[2], blend_ch[1], blend_ch[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= b_vld_r && b_side_r.is_frag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_px_r <= b_write_r;
      color_r <= color_nxt;
      depth_r <= b_side_r.frag_depth;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, depth_r, color_r, wr_px_r};

endmodule

### src/texture_fragment_depth_unit.sv
// Top level of the texture fragment depth unit: configuration registers,
// front queue and back pipeline. Depends on tfd_pkg, tfd_front, tfd_back.
//
//  channel  | dir | handshake          | payload
//  in_      | in  | in_tvalid/tready   | in_tdata: load texel or fragment
//  out_     | out | out_tvalid/tready  | out_tdata: write flag, color, depth
//  cfg_     | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One request per cycle sustained while results are not stalled; a fragment
// result is computed through the 36-stage bit-per-stage coordinate dividers.
// Four texture store copies let four neighbours read per cycle unless stalled.
// Reset clears queue, valid bits and config registers; not the texture store.
// A stalled result freezes the back pipeline; the front queue keeps accepting
// until its four entries are full.
module texture_fragment_depth_unit import tfd_pkg::*; #(
  parameter int TEX_ADDR_BITS = TEX_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode, texel_addr, texel_value, frag_depth, buffer_depth, s_over_w,
  // t_over_w, one_over_w (lowest first), zero padded
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // write_pixel, pixel_color, depth_out (lowest first), zero padded
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  logic [7:0] s_mask_r, t_mask_r;
  logic [3:0] row_shift_r;
  logic       filter_mode_r;
  head_t      head;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_mask_r      <= 8'hff;
      t_mask_r      <= 8'hff;
      row_shift_r   <= 4'd8;
      filter_mode_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_S_MASK:      s_mask_r      <= cfg_data;
        REG_T_MASK:      t_mask_r      <= cfg_data;
        REG_ROW_SHIFT:   row_shift_r   <= cfg_data[3:0];
        REG_FILTER_MODE: filter_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .head      (head)
  );

  tfd_back #(.TEX_ADDR_BITS(TEX_ADDR_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .s_mask      (s_mask_r),
    .t_mask      (t_mask_r),
    .row_shift   (row_shift_r),
    .filter_mode (filter_mode_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

### src/tfd_checker.sv
// Port-level checks for the texture fragment depth unit, bound to the top.
// Depends on tfd_pkg.
module tfd_checker import tfd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:49] == '0)
    else $error("padding bits set");

  a_color_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == '0)
    else $error("color on a rejected fragment");

endmodule

bind texture_fragment_depth_unit tfd_checker u_tfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
